// ===== sv/oor_pkg.sv =====
// ============================================================================
// oor_pkg - shared types, constants and helpers of the obstacle router
// Coordinate types, store sizing, score constants and small geometry helpers.
// ============================================================================
package oor_pkg;

    localparam int MAX_BOXES = 16;
    localparam int ADDR_W    = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int BOX_W     = 64;
    localparam int COORD_W   = 20;
    localparam int OUT_W     = 18;
    localparam int PAD_W     = 10;
    localparam int LEN_W     = 22;
    localparam int SCORE_W   = 24;
    localparam int MAX_PTS   = 6;

    localparam int DETOUR_EXTRA = 20;
    localparam int POINT_WEIGHT = 1000000;
    localparam int PORT_BONUS   = 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SCORE_W-1:0]        score_t;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_RIGHT,
        DIR_LEFT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [2:0] {
        CK_STRAIGHT,
        CK_L1,
        CK_L2,
        CK_SIDEX,
        CK_SIDEY,
        CK_CORNER,
        CK_LOOP
    } cand_kind_t;

    // Sign-extend a 16-bit field to the coordinate width
    function automatic coord_t sext16(input logic [15:0] v);
        return coord_t'(signed'(v));
    endfunction

    // Port side of a point against the uninflated box, tested right, left, top, bottom
    function automatic dir_t port_side(input coord_t px, input coord_t py,
                                       input logic [BOX_W-1:0] raw);
        coord_t bx;
        coord_t by;
        coord_t bw;
        coord_t bh;
        dir_t   d;
        bx = sext16(raw[15:0]);
        by = sext16(raw[31:16]);
        bw = sext16(raw[47:32]);
        bh = sext16(raw[63:48]);
        if (px >= bx + bw - coord_t'(1))      d = DIR_RIGHT;
        else if (px <= bx + coord_t'(1))      d = DIR_LEFT;
        else if (py <= by + coord_t'(1))      d = DIR_UP;
        else if (py >= by + bh - coord_t'(1)) d = DIR_DOWN;
        else                                  d = DIR_NONE;
        return d;
    endfunction

    // Mirror a side so that it names the arriving direction at the target
    function automatic dir_t flip_dir(input dir_t d);
        dir_t r;
        case (d)
            DIR_RIGHT: r = DIR_LEFT;
            DIR_LEFT:  r = DIR_RIGHT;
            DIR_UP:    r = DIR_DOWN;
            DIR_DOWN:  r = DIR_UP;
            default:   r = DIR_NONE;
        endcase
        return r;
    endfunction

    // Dominant direction of a segment
    function automatic dir_t seg_dir(input coord_t ax, input coord_t ay,
                                     input coord_t bx, input coord_t by);
        coord_t dx;
        coord_t dy;
        dir_t   d;
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        if (dx > dy)         d = (bx > ax) ? DIR_RIGHT : DIR_LEFT;
        else if (dy != '0)   d = (by > ay) ? DIR_DOWN : DIR_UP;
        else                 d = DIR_NONE;
        return d;
    endfunction

endpackage

// ===== sv/orthogonal_obstacle_router_top.sv =====
// ============================================================================
// orthogonal_obstacle_router_top - orthogonal router round stored obstacles
// Loads obstacle boxes, then routes source to target along the best
// unblocked candidate polyline and streams its vertices.
// ============================================================================
//  channel | direction | tdata / data                    | tuser / tlast
//  s_      | in        | box l,t,w,h, src x,y, dst x,y   | tuser req_type
//  m_      | out       | point_x, point_y                | tuser dropped, tlast last
//  cfg_    | in        | clearance                       | -
//
// A load beat is stored straight from idle; a route beat runs a box scan, then for each
// candidate (8N+12 of them, N boxes) a build step, a scan of its segments through the box
// memory read port until one is blocked, and a score step if none is blocked.
// The chosen points are then emitted, one point per beat, advancing while m_tready is high.
// Reset clears the box count, the overflow flag and the clearance.
// s_tready is low from a route beat until its last point is taken.
// ============================================================================
module orthogonal_obstacle_router_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // box_left, box_top, box_width, box_height,
                                    // src_x, src_y, dst_x, dst_y (16 bits each)
    input  logic         s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // point_x [17:0], point_y [35:18], zero fill
    output logic         m_tlast,   // last_point
    output logic         m_tuser,   // dropped_boxes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [9:0]   cfg_data   // clearance
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEOM,
        S_SIDES,
        S_CAND,
        S_BOXRD,
        S_BOXSET,
        S_SEGSET,
        S_SEGSCAN,
        S_SCORE,
        S_FINAL,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_FIX,
        PH_BOX,
        PH_LOOP
    } phase_t;

    localparam logic [3:0] FIX_LAST = 4'd10;
    localparam logic [2:0] SUB_LAST = 3'd7;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [oor_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [oor_pkg::PAD_W-1:0]  pad_reg, pad_next;

    oor_pkg::coord_t sx_reg, sx_next, sy_reg, sy_next, tx_reg, tx_next, ty_reg, ty_next;
    oor_pkg::coord_t gx1_reg, gx1_next, gx2_reg, gx2_next;
    oor_pkg::coord_t gy1_reg, gy1_next, gy2_reg, gy2_next;
    oor_pkg::coord_t xr_reg, xr_next, xl_reg, xl_next, yb_reg, yb_next, yt_reg, yt_next;
    oor_pkg::coord_t gap_reg, gap_next;
    oor_pkg::coord_t ox0_reg, ox0_next, ox1_reg, ox1_next;
    oor_pkg::coord_t oy0_reg, oy0_next, oy1_reg, oy1_next;

    logic                       sfound_reg, sfound_next, dfound_reg, dfound_next;
    logic [oor_pkg::BOX_W-1:0]  sbox_reg, sbox_next, dbox_reg, dbox_next;
    oor_pkg::dir_t              sside_reg, sside_next, dside_reg, dside_next;

    logic [3:0]                 fix_reg, fix_next;
    logic [oor_pkg::ADDR_W-1:0] box_reg, box_next;
    logic [2:0]                 sub_reg, sub_next;

    oor_pkg::coord_t cx_reg [oor_pkg::MAX_PTS];
    oor_pkg::coord_t cx_next [oor_pkg::MAX_PTS];
    oor_pkg::coord_t cy_reg [oor_pkg::MAX_PTS];
    oor_pkg::coord_t cy_next [oor_pkg::MAX_PTS];
    logic [2:0]      cn_reg, cn_next;

    logic [2:0]                 seg_reg, seg_next;
    logic                       vert_reg, vert_next, degen_reg, degen_next;
    oor_pkg::coord_t            a_reg, a_next, lo_reg, lo_next, hi_reg, hi_next;
    logic                       blk_reg, blk_next;
    logic [oor_pkg::LEN_W-1:0]  len_reg, len_next;

    logic [oor_pkg::CNT_W-1:0]  issue_reg, issue_next;
    logic                       chk_reg, chk_next;

    logic                       have_reg, have_next;
    oor_pkg::score_t            best_reg, best_next;
    oor_pkg::coord_t bx_reg [oor_pkg::MAX_PTS];
    oor_pkg::coord_t bx_next [oor_pkg::MAX_PTS];
    oor_pkg::coord_t by_reg [oor_pkg::MAX_PTS];
    oor_pkg::coord_t by_next [oor_pkg::MAX_PTS];
    logic [2:0]      bn_reg, bn_next, emit_reg, emit_next;

    // memory port
    logic                       ram_we;
    logic [oor_pkg::ADDR_W-1:0] ram_raddr;
    logic [oor_pkg::BOX_W-1:0]  ram_rdata;

    // inflated box of the word just read
    oor_pkg::coord_t padc, il, it, ir, ib;
    logic            in_src, in_dst, hit;

    // scan control
    logic scan_go, scan_done;

    // candidate generator
    oor_pkg::cand_kind_t gkind;
    oor_pkg::coord_t     gx, gy;
    oor_pkg::coord_t     px [oor_pkg::MAX_PTS];
    oor_pkg::coord_t     py [oor_pkg::MAX_PTS];
    logic [2:0]          pn;

    // advance to the next candidate
    state_t                     adv_state;
    phase_t                     adv_phase;
    logic [3:0]                 adv_fix;
    logic [oor_pkg::ADDR_W-1:0] adv_box;
    logic [2:0]                 adv_sub;

    // segment set-up and scoring
    oor_pkg::coord_t  p0x, p0y, p1x, p1y, sdx, sdy;
    oor_pkg::score_t  score;
    logic [6:0]       bonus;
    logic             box_ok;

    oor_ram #(
        .WIDTH(oor_pkg::BOX_W),
        .DEPTH(oor_pkg::MAX_BOXES)
    ) u_box_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[oor_pkg::ADDR_W-1:0]),
        .wdata (s_tdata[63:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // inflate the box read last cycle
    always_comb begin
        padc = oor_pkg::coord_t'({1'b0, pad_reg});
        il   = oor_pkg::sext16(ram_rdata[15:0]) - padc;
        it   = oor_pkg::sext16(ram_rdata[31:16]) - padc;
        ir   = oor_pkg::sext16(ram_rdata[15:0]) + oor_pkg::sext16(ram_rdata[47:32]) + padc;
        ib   = oor_pkg::sext16(ram_rdata[31:16]) + oor_pkg::sext16(ram_rdata[63:48]) + padc;
        in_src = (sx_reg >= il) && (sx_reg <= ir) && (sy_reg >= it) && (sy_reg <= ib);
        in_dst = (tx_reg >= il) && (tx_reg <= ir) && (ty_reg >= it) && (ty_reg <= ib);
        if (vert_reg) begin
            hit = (a_reg > il) && (a_reg < ir) && (hi_reg > it) && (lo_reg < ib);
        end else begin
            hit = (a_reg > it) && (a_reg < ib) && (hi_reg > il) && (lo_reg < ir);
        end
    end

    // scan pointer and read address
    always_comb begin
        scan_go   = issue_reg < cnt_reg;
        scan_done = !scan_go && !chk_reg;
        ram_raddr = (state_reg == S_BOXRD) ? box_reg : issue_reg[oor_pkg::ADDR_W-1:0];
        box_ok    = (s_tdata[47:32] != 16'd0) && !s_tdata[47] &&
                    (s_tdata[63:48] != 16'd0) && !s_tdata[63];
        ram_we    = (state_reg == S_IDLE) && s_tvalid && !s_tuser && box_ok &&
                    (cnt_reg < oor_pkg::CNT_W'(oor_pkg::MAX_BOXES));
    end

    // pick the candidate kind and its detour lines
    always_comb begin
        gkind = oor_pkg::CK_STRAIGHT;
        gx    = xr_reg;
        gy    = yb_reg;
        case (phase_reg)
            PH_FIX: begin
                case (fix_reg)
                    4'd0:    gkind = oor_pkg::CK_STRAIGHT;
                    4'd1:    gkind = oor_pkg::CK_L1;
                    4'd2:    gkind = oor_pkg::CK_L2;
                    4'd3:    begin gkind = oor_pkg::CK_SIDEX;  gx = xr_reg; end
                    4'd4:    begin gkind = oor_pkg::CK_SIDEX;  gx = xl_reg; end
                    4'd5:    begin gkind = oor_pkg::CK_SIDEY;  gy = yb_reg; end
                    4'd6:    begin gkind = oor_pkg::CK_SIDEY;  gy = yt_reg; end
                    4'd7:    begin gkind = oor_pkg::CK_CORNER; gx = xr_reg; gy = yb_reg; end
                    4'd8:    begin gkind = oor_pkg::CK_CORNER; gx = xr_reg; gy = yt_reg; end
                    4'd9:    begin gkind = oor_pkg::CK_CORNER; gx = xl_reg; gy = yb_reg; end
                    4'd10:   begin gkind = oor_pkg::CK_CORNER; gx = xl_reg; gy = yt_reg; end
                    default: gkind = oor_pkg::CK_STRAIGHT;
                endcase
            end
            PH_BOX: begin
                case (sub_reg)
                    3'd0:    begin gkind = oor_pkg::CK_SIDEX;  gx = ox0_reg; end
                    3'd1:    begin gkind = oor_pkg::CK_CORNER; gx = ox0_reg; gy = oy0_reg; end
                    3'd2:    begin gkind = oor_pkg::CK_CORNER; gx = ox0_reg; gy = oy1_reg; end
                    3'd3:    begin gkind = oor_pkg::CK_SIDEX;  gx = ox1_reg; end
                    3'd4:    begin gkind = oor_pkg::CK_CORNER; gx = ox1_reg; gy = oy0_reg; end
                    3'd5:    begin gkind = oor_pkg::CK_CORNER; gx = ox1_reg; gy = oy1_reg; end
                    3'd6:    begin gkind = oor_pkg::CK_SIDEY;  gy = oy0_reg; end
                    default: begin gkind = oor_pkg::CK_SIDEY;  gy = oy1_reg; end
                endcase
            end
            default: gkind = oor_pkg::CK_LOOP;
        endcase
    end

    // build the polyline of the chosen kind
    always_comb begin
        for (int k = 0; k < oor_pkg::MAX_PTS; k++) begin
            px[k] = tx_reg;
            py[k] = ty_reg;
        end
        px[0] = sx_reg;
        py[0] = sy_reg;
        pn    = 3'd2;
        case (gkind)
            oor_pkg::CK_STRAIGHT: pn = 3'd2;
            oor_pkg::CK_L1: begin
                px[1] = tx_reg; py[1] = sy_reg; pn = 3'd3;
            end
            oor_pkg::CK_L2: begin
                px[1] = sx_reg; py[1] = ty_reg; pn = 3'd3;
            end
            oor_pkg::CK_SIDEX: begin
                px[1] = gx; py[1] = sy_reg;
                px[2] = gx; py[2] = ty_reg; pn = 3'd4;
            end
            oor_pkg::CK_SIDEY: begin
                px[1] = sx_reg; py[1] = gy;
                px[2] = tx_reg; py[2] = gy; pn = 3'd4;
            end
            oor_pkg::CK_CORNER: begin
                px[1] = gx;     py[1] = sy_reg;
                px[2] = gx;     py[2] = gy;
                px[3] = tx_reg; py[3] = gy; pn = 3'd5;
            end
            oor_pkg::CK_LOOP: begin
                px[1] = sx_reg; py[1] = yt_reg;
                px[2] = xr_reg; py[2] = yt_reg;
                px[3] = xr_reg; py[3] = yb_reg;
                px[4] = tx_reg; py[4] = yb_reg; pn = 3'd6;
            end
            default: pn = 3'd2;
        endcase
    end

    // step to the next candidate in list order
    always_comb begin
        adv_state = S_CAND;
        adv_phase = phase_reg;
        adv_fix   = fix_reg;
        adv_box   = box_reg;
        adv_sub   = sub_reg;
        case (phase_reg)
            PH_FIX: begin
                if (fix_reg == FIX_LAST) begin
                    if (cnt_reg != '0) begin
                        adv_phase = PH_BOX;
                        adv_box   = '0;
                        adv_sub   = '0;
                        adv_state = S_BOXRD;
                    end else begin
                        adv_phase = PH_LOOP;
                    end
                end else begin
                    adv_fix = fix_reg + 4'd1;
                end
            end
            PH_BOX: begin
                if (sub_reg == SUB_LAST) begin
                    if ({1'b0, box_reg} == cnt_reg - oor_pkg::CNT_W'(1)) begin
                        adv_phase = PH_LOOP;
                    end else begin
                        adv_box   = box_reg + oor_pkg::ADDR_W'(1);
                        adv_sub   = '0;
                        adv_state = S_BOXRD;
                    end
                end else begin
                    adv_sub = sub_reg + 3'd1;
                end
            end
            default: adv_state = S_FINAL;
        endcase
    end

    // segment end points and candidate score
    always_comb begin
        p0x = cx_reg[seg_reg];
        p0y = cy_reg[seg_reg];
        p1x = cx_reg[seg_reg + 3'd1];
        p1y = cy_reg[seg_reg + 3'd1];
        sdx = (p1x > p0x) ? p1x - p0x : p0x - p1x;
        sdy = (p1y > p0y) ? p1y - p0y : p0y - p1y;
        bonus = '0;
        if (sside_reg != oor_pkg::DIR_NONE &&
            oor_pkg::seg_dir(cx_reg[0], cy_reg[0], cx_reg[1], cy_reg[1]) == sside_reg) begin
            bonus = bonus + 7'(oor_pkg::PORT_BONUS);
        end
        if (dside_reg != oor_pkg::DIR_NONE &&
            oor_pkg::seg_dir(cx_reg[cn_reg - 3'd2], cy_reg[cn_reg - 3'd2],
                             cx_reg[cn_reg - 3'd1], cy_reg[cn_reg - 3'd1]) == dside_reg) begin
            bonus = bonus + 7'(oor_pkg::PORT_BONUS);
        end
        score = oor_pkg::SCORE_W'(cn_reg) * oor_pkg::SCORE_W'(oor_pkg::POINT_WEIGHT)
              + oor_pkg::SCORE_W'(len_reg) - oor_pkg::SCORE_W'(bonus);
    end

    // sequencer next state
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        pad_next    = pad_reg;
        sx_next = sx_reg; sy_next = sy_reg; tx_next = tx_reg; ty_next = ty_reg;
        gx1_next = gx1_reg; gx2_next = gx2_reg; gy1_next = gy1_reg; gy2_next = gy2_reg;
        xr_next = xr_reg; xl_next = xl_reg; yb_next = yb_reg; yt_next = yt_reg;
        gap_next = gap_reg;
        ox0_next = ox0_reg; ox1_next = ox1_reg; oy0_next = oy0_reg; oy1_next = oy1_reg;
        sfound_next = sfound_reg; dfound_next = dfound_reg;
        sbox_next = sbox_reg; dbox_next = dbox_reg;
        sside_next = sside_reg; dside_next = dside_reg;
        fix_next = fix_reg; box_next = box_reg; sub_next = sub_reg;
        cx_next = cx_reg; cy_next = cy_reg; cn_next = cn_reg;
        seg_next = seg_reg; vert_next = vert_reg; degen_next = degen_reg;
        a_next = a_reg; lo_next = lo_reg; hi_next = hi_reg;
        blk_next = blk_reg; len_next = len_reg;
        issue_next = issue_reg; chk_next = chk_reg;
        have_next = have_reg; best_next = best_reg;
        bx_next = bx_reg; by_next = by_reg; bn_next = bn_reg; emit_next = emit_reg;

        if (cfg_valid) begin
            pad_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        // store a valid box, or flag it dropped when the store is full
                        if (box_ok) begin
                            if (ram_we) cnt_next = cnt_reg + oor_pkg::CNT_W'(1);
                            else        ovf_next = 1'b1;
                        end
                    end else begin
                        sx_next = oor_pkg::sext16(s_tdata[79:64]);
                        sy_next = oor_pkg::sext16(s_tdata[95:80]);
                        tx_next = oor_pkg::sext16(s_tdata[111:96]);
                        ty_next = oor_pkg::sext16(s_tdata[127:112]);
                        have_next = 1'b0;
                        emit_next = '0;
                        if (s_tdata[95:64] == s_tdata[127:96]) begin
                            bx_next[0] = oor_pkg::sext16(s_tdata[79:64]);
                            by_next[0] = oor_pkg::sext16(s_tdata[95:80]);
                            bn_next    = 3'd1;
                            state_next = S_EMIT;
                        end else begin
                            gx1_next = oor_pkg::sext16(s_tdata[79:64]);
                            gx2_next = oor_pkg::sext16(s_tdata[79:64]);
                            gy1_next = oor_pkg::sext16(s_tdata[95:80]);
                            gy2_next = oor_pkg::sext16(s_tdata[95:80]);
                            sfound_next = 1'b0;
                            dfound_next = 1'b0;
                            issue_next  = '0;
                            chk_next    = 1'b0;
                            state_next  = S_GEOM;
                        end
                    end
                end
            end
            S_GEOM: begin
                // sweep boxes: field extent and port boxes
                issue_next = issue_reg + oor_pkg::CNT_W'(scan_go);
                chk_next   = scan_go;
                if (chk_reg) begin
                    if (il < gx1_reg) gx1_next = il;
                    if (ir > gx2_reg) gx2_next = ir;
                    if (it < gy1_reg) gy1_next = it;
                    if (ib > gy2_reg) gy2_next = ib;
                    if (!sfound_reg && in_src) begin
                        sfound_next = 1'b1;
                        sbox_next   = ram_rdata;
                    end
                    if (!dfound_reg && in_dst) begin
                        dfound_next = 1'b1;
                        dbox_next   = ram_rdata;
                    end
                end
                if (scan_done) state_next = S_SIDES;
            end
            S_SIDES: begin
                gap_next = padc + oor_pkg::coord_t'(oor_pkg::DETOUR_EXTRA);
                xr_next  = gx2_reg + padc + oor_pkg::coord_t'(oor_pkg::DETOUR_EXTRA);
                xl_next  = gx1_reg - padc - oor_pkg::coord_t'(oor_pkg::DETOUR_EXTRA);
                yb_next  = gy2_reg + padc + oor_pkg::coord_t'(oor_pkg::DETOUR_EXTRA);
                yt_next  = gy1_reg - padc - oor_pkg::coord_t'(oor_pkg::DETOUR_EXTRA);
                sside_next = sfound_reg ? oor_pkg::port_side(sx_reg, sy_reg, sbox_reg)
                                        : oor_pkg::DIR_NONE;
                dside_next = dfound_reg ?
                    oor_pkg::flip_dir(oor_pkg::port_side(tx_reg, ty_reg, dbox_reg)) :
                    oor_pkg::DIR_NONE;
                phase_next = PH_FIX;
                fix_next   = '0;
                state_next = S_CAND;
            end
            S_BOXRD: begin
                state_next = S_BOXSET;
            end
            S_BOXSET: begin
                ox0_next = il - gap_reg;
                ox1_next = ir + gap_reg;
                oy0_next = it - gap_reg;
                oy1_next = ib + gap_reg;
                state_next = S_CAND;
            end
            S_CAND: begin
                // skip the straight line unless the ends share an axis
                if (gkind == oor_pkg::CK_STRAIGHT && sx_reg != tx_reg && sy_reg != ty_reg) begin
                    state_next = adv_state;
                    phase_next = adv_phase;
                    fix_next   = adv_fix;
                    box_next   = adv_box;
                    sub_next   = adv_sub;
                end else begin
                    cx_next  = px;
                    cy_next  = py;
                    cn_next  = pn;
                    seg_next = '0;
                    blk_next = 1'b0;
                    len_next = '0;
                    state_next = S_SEGSET;
                end
            end
            S_SEGSET: begin
                vert_next  = (p0x == p1x);
                degen_next = (p0x == p1x) && (p0y == p1y);
                if (p0x == p1x) begin
                    a_next  = p0x;
                    lo_next = (p0y < p1y) ? p0y : p1y;
                    hi_next = (p0y > p1y) ? p0y : p1y;
                end else begin
                    a_next  = p0y;
                    lo_next = (p0x < p1x) ? p0x : p1x;
                    hi_next = (p0x > p1x) ? p0x : p1x;
                end
                len_next   = len_reg + oor_pkg::LEN_W'(sdx) + oor_pkg::LEN_W'(sdy);
                issue_next = '0;
                chk_next   = 1'b0;
                state_next = S_SEGSCAN;
            end
            S_SEGSCAN: begin
                // test the segment against every inflated box
                issue_next = issue_reg + oor_pkg::CNT_W'(scan_go);
                chk_next   = scan_go;
                if (chk_reg && !degen_reg && hit) blk_next = 1'b1;
                if (scan_done) begin
                    if (blk_reg) begin
                        state_next = adv_state;
                        phase_next = adv_phase;
                        fix_next   = adv_fix;
                        box_next   = adv_box;
                        sub_next   = adv_sub;
                    end else if (seg_reg == cn_reg - 3'd2) begin
                        state_next = S_SCORE;
                    end else begin
                        seg_next   = seg_reg + 3'd1;
                        state_next = S_SEGSET;
                    end
                end
            end
            S_SCORE: begin
                // keep the earliest lowest score
                if (!have_reg || score < best_reg) begin
                    have_next = 1'b1;
                    best_next = score;
                    bx_next   = cx_reg;
                    by_next   = cy_reg;
                    bn_next   = cn_reg;
                end
                state_next = adv_state;
                phase_next = adv_phase;
                fix_next   = adv_fix;
                box_next   = adv_box;
                sub_next   = adv_sub;
            end
            S_FINAL: begin
                // fall back to the right-and-below route
                if (!have_reg) begin
                    bx_next[0] = sx_reg; by_next[0] = sy_reg;
                    bx_next[1] = xr_reg; by_next[1] = sy_reg;
                    bx_next[2] = xr_reg; by_next[2] = yb_reg;
                    bx_next[3] = tx_reg; by_next[3] = yb_reg;
                    bx_next[4] = tx_reg; by_next[4] = ty_reg;
                    bn_next    = 3'd5;
                end
                emit_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (m_tready) begin
                    if (emit_reg == bn_reg - 3'd1) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        emit_next = emit_reg + 3'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FIX;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            pad_reg   <= '0;
            issue_reg <= '0;
            chk_reg   <= 1'b0;
            have_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            pad_reg   <= pad_next;
            issue_reg <= issue_next;
            chk_reg   <= chk_next;
            have_reg  <= have_next;
        end
        sx_reg <= sx_next; sy_reg <= sy_next; tx_reg <= tx_next; ty_reg <= ty_next;
        gx1_reg <= gx1_next; gx2_reg <= gx2_next; gy1_reg <= gy1_next; gy2_reg <= gy2_next;
        xr_reg <= xr_next; xl_reg <= xl_next; yb_reg <= yb_next; yt_reg <= yt_next;
        gap_reg <= gap_next;
        ox0_reg <= ox0_next; ox1_reg <= ox1_next; oy0_reg <= oy0_next; oy1_reg <= oy1_next;
        sfound_reg <= sfound_next; dfound_reg <= dfound_next;
        sbox_reg <= sbox_next; dbox_reg <= dbox_next;
        sside_reg <= sside_next; dside_reg <= dside_next;
        fix_reg <= fix_next; box_reg <= box_next; sub_reg <= sub_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cn_reg <= cn_next;
        seg_reg <= seg_next; vert_reg <= vert_next; degen_reg <= degen_next;
        a_reg <= a_next; lo_reg <= lo_next; hi_reg <= hi_next;
        blk_reg <= blk_next; len_reg <= len_next;
        best_reg <= best_next;
        bx_reg <= bx_next; by_reg <= by_next; bn_reg <= bn_next; emit_reg <= emit_next;
    end

    // drive the ports
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_EMIT);
    assign m_tdata   = {4'b0000, by_reg[emit_reg][oor_pkg::OUT_W-1:0],
                        bx_reg[emit_reg][oor_pkg::OUT_W-1:0]};
    assign m_tlast   = (emit_reg == bn_reg - 3'd1);
    assign m_tuser   = ovf_reg;

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input ready while a point is shown");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= oor_pkg::CNT_W'(oor_pkg::MAX_BOXES)) else $error("box count past capacity");
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> cnt_reg == '0 && !ovf_reg)
        else $error("store not cleared after route");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_reg <= cnt_reg || state_reg == S_IDLE || state_reg == S_EMIT)
        else $error("scan ran past the stored boxes");
`endif

endmodule

// ===== sv/oor_ram.sv =====
// ============================================================================
// oor_ram - generic single-port-write, registered-read memory
// One write port and one read port, read data valid the cycle after address.
// ============================================================================
module oor_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/tb_orthogonal_obstacle_router_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_orthogonal_obstacle_router_top - self-checking bench of the obstacle router
// Loads obstacle boxes and routes between points under several clearances,
// predicts every route vertex and compares each output beat field by field.
// ============================================================================
module tb_orthogonal_obstacle_router_top;

    typedef struct packed {
        logic         req;
        logic [127:0] data;
    } req_beat_t;

    typedef struct packed {
        logic signed [17:0] px;
        logic signed [17:0] py;
        logic               last;
        logic               dropped;
    } vertex_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [9:0]   cfg_data;

    orthogonal_obstacle_router_top dut (.*);

    // Bench state: predictor copy of the block and queues
    req_beat_t pending_beats[$];
    vertex_t   route_points[$];
    logic [63:0] model_boxes[oor_pkg::MAX_BOXES];
    int          model_count = 0;
    bit          model_overflow = 1'b0;
    int          model_pad;
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_sender;
    bit          done;

    // Predictor working set
    int ibx[oor_pkg::MAX_BOXES], iby[oor_pkg::MAX_BOXES];
    int ibw[oor_pkg::MAX_BOXES], ibh[oor_pkg::MAX_BOXES];
    int nbox;
    int src_side, dst_side;
    bit have_best;
    longint best_score;
    int best_n;
    int best_x[6], best_y[6];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int sx16(input logic [15:0] v);
        return int'(signed'(v));
    endfunction

    function automatic int iabs(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit crosses_box(input int x1, input int y1, input int x2, input int y2);
        bit vert;
        int lo, hi, a;
        vert = (x1 == x2);
        if (x1 == x2 && y1 == y2) return 1'b0;
        lo = vert ? (y1 < y2 ? y1 : y2) : (x1 < x2 ? x1 : x2);
        hi = vert ? (y1 > y2 ? y1 : y2) : (x1 > x2 ? x1 : x2);
        a  = vert ? x1 : y1;
        for (int i = 0; i < nbox; i++) begin
            if (vert) begin
                if (a > ibx[i] && a < ibx[i] + ibw[i] && hi > iby[i] && lo < iby[i] + ibh[i])
                    return 1'b1;
            end else begin
                if (a > iby[i] && a < iby[i] + ibh[i] && hi > ibx[i] && lo < ibx[i] + ibw[i])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic oor_pkg::dir_t heading(input int ax, input int ay,
                                              input int bx, input int by);
        int dx, dy;
        dx = iabs(bx - ax);
        dy = iabs(by - ay);
        if (dx > dy) return bx > ax ? oor_pkg::DIR_RIGHT : oor_pkg::DIR_LEFT;
        if (dy != 0) return by > ay ? oor_pkg::DIR_DOWN : oor_pkg::DIR_UP;
        return oor_pkg::DIR_NONE;
    endfunction

    function automatic int side_of(input int idx, input int px, input int py);
        int bx, by, bw, bh;
        if (idx < 0) return oor_pkg::DIR_NONE;
        bx = sx16(model_boxes[idx][15:0]);
        by = sx16(model_boxes[idx][31:16]);
        bw = sx16(model_boxes[idx][47:32]);
        bh = sx16(model_boxes[idx][63:48]);
        if (px >= bx + bw - 1) return oor_pkg::DIR_RIGHT;
        if (px <= bx + 1) return oor_pkg::DIR_LEFT;
        if (py <= by + 1) return oor_pkg::DIR_UP;
        if (py >= by + bh - 1) return oor_pkg::DIR_DOWN;
        return oor_pkg::DIR_NONE;
    endfunction

    // Append a request beat to the driver queue
    task automatic add_beat(input req_beat_t b);
        pending_beats = {pending_beats, b};
    endtask

    // Score one candidate polyline and keep it if it beats the best so far
    task automatic weigh_path(input int px[6], input int py[6], input int n);
        longint score, len;
        len = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (crosses_box(px[i], py[i], px[i+1], py[i+1])) return;
            len += iabs(px[i+1] - px[i]) + iabs(py[i+1] - py[i]);
        end
        score = longint'(n) * oor_pkg::POINT_WEIGHT + len;
        if (src_side != oor_pkg::DIR_NONE &&
            heading(px[0], py[0], px[1], py[1]) == oor_pkg::dir_t'(src_side))
            score -= oor_pkg::PORT_BONUS;
        if (dst_side != oor_pkg::DIR_NONE &&
            heading(px[n-2], py[n-2], px[n-1], py[n-1]) == oor_pkg::dir_t'(dst_side))
            score -= oor_pkg::PORT_BONUS;
        if (!have_best || score < best_score) begin
            have_best  = 1'b1;
            best_score = score;
            best_n     = n;
            for (int i = 0; i < n; i++) begin
                best_x[i] = px[i];
                best_y[i] = py[i];
            end
        end
    endtask

    task automatic via_x(input int sx, input int sy, input int tx, input int ty, input int x);
        weigh_path('{sx, x, x, tx, 0, 0}, '{sy, sy, ty, ty, 0, 0}, 4);
    endtask

    task automatic via_y(input int sx, input int sy, input int tx, input int ty, input int y);
        weigh_path('{sx, sx, tx, tx, 0, 0}, '{sy, y, y, ty, 0, 0}, 4);
    endtask

    task automatic via_corner(input int sx, input int sy, input int tx, input int ty,
                              input int x, input int y);
        weigh_path('{sx, x, x, tx, tx, 0}, '{sy, sy, y, y, ty, 0}, 5);
    endtask

    // Apply one request to the model; a route queues its vertices
    task automatic predict_request(input req_beat_t b);
        int sx, sy, tx, ty, w, h, gap, gx1, gx2, gy1, gy2, xR, xL, yB, yT, si, di, s;
        vertex_t v;
        if (!b.req) begin
            w = sx16(b.data[47:32]);
            h = sx16(b.data[63:48]);
            if (w <= 0 || h <= 0) return;
            if (model_count < oor_pkg::MAX_BOXES) begin
                model_boxes[model_count] = b.data[63:0];
                model_count++;
            end else begin
                model_overflow = 1'b1;
            end
            return;
        end
        sx = sx16(b.data[79:64]);
        sy = sx16(b.data[95:80]);
        tx = sx16(b.data[111:96]);
        ty = sx16(b.data[127:112]);
        have_best = 1'b0;
        si = -1;
        di = -1;
        if (sx == tx && sy == ty) begin
            best_n = 1;
            best_x[0] = sx;
            best_y[0] = sy;
        end else begin
            nbox = model_count;
            for (int i = 0; i < nbox; i++) begin
                ibx[i] = sx16(model_boxes[i][15:0]) - model_pad;
                iby[i] = sx16(model_boxes[i][31:16]) - model_pad;
                ibw[i] = sx16(model_boxes[i][47:32]) + 2 * model_pad;
                ibh[i] = sx16(model_boxes[i][63:48]) + 2 * model_pad;
                if (si < 0 && sx >= ibx[i] && sx <= ibx[i] + ibw[i] &&
                    sy >= iby[i] && sy <= iby[i] + ibh[i]) si = i;
                if (di < 0 && tx >= ibx[i] && tx <= ibx[i] + ibw[i] &&
                    ty >= iby[i] && ty <= iby[i] + ibh[i]) di = i;
            end
            gx1 = sx; gx2 = sx; gy1 = sy; gy2 = sy;
            for (int i = 0; i < nbox; i++) begin
                if (ibx[i] < gx1) gx1 = ibx[i];
                if (ibx[i] + ibw[i] > gx2) gx2 = ibx[i] + ibw[i];
                if (iby[i] < gy1) gy1 = iby[i];
                if (iby[i] + ibh[i] > gy2) gy2 = iby[i] + ibh[i];
            end
            gap = model_pad + oor_pkg::DETOUR_EXTRA;
            xR = gx2 + gap; xL = gx1 - gap;
            yB = gy2 + gap; yT = gy1 - gap;
            src_side = side_of(si, sx, sy);
            s = side_of(di, tx, ty);
            dst_side = oor_pkg::flip_dir(oor_pkg::dir_t'(s));
            if (sx == tx || sy == ty)
                weigh_path('{sx, tx, 0, 0, 0, 0}, '{sy, ty, 0, 0, 0, 0}, 2);
            weigh_path('{sx, tx, tx, 0, 0, 0}, '{sy, sy, ty, 0, 0, 0}, 3);
            weigh_path('{sx, sx, tx, 0, 0, 0}, '{sy, ty, ty, 0, 0, 0}, 3);
            via_x(sx, sy, tx, ty, xR);
            via_x(sx, sy, tx, ty, xL);
            via_y(sx, sy, tx, ty, yB);
            via_y(sx, sy, tx, ty, yT);
            via_corner(sx, sy, tx, ty, xR, yB);
            via_corner(sx, sy, tx, ty, xR, yT);
            via_corner(sx, sy, tx, ty, xL, yB);
            via_corner(sx, sy, tx, ty, xL, yT);
            for (int i = 0; i < nbox; i++) begin
                int ox[2], oy[2];
                ox[0] = ibx[i] - gap; ox[1] = ibx[i] + ibw[i] + gap;
                oy[0] = iby[i] - gap; oy[1] = iby[i] + ibh[i] + gap;
                for (int k = 0; k < 2; k++) begin
                    via_x(sx, sy, tx, ty, ox[k]);
                    via_corner(sx, sy, tx, ty, ox[k], oy[0]);
                    via_corner(sx, sy, tx, ty, ox[k], oy[1]);
                end
                via_y(sx, sy, tx, ty, oy[0]);
                via_y(sx, sy, tx, ty, oy[1]);
            end
            weigh_path('{sx, sx, xR, xR, tx, tx}, '{sy, yT, yT, yB, yB, ty}, 6);
            if (!have_best) begin
                best_n = 5;
                best_x[0] = sx; best_x[1] = xR; best_x[2] = xR; best_x[3] = tx; best_x[4] = tx;
                best_y[0] = sy; best_y[1] = sy; best_y[2] = yB; best_y[3] = yB; best_y[4] = ty;
            end
        end
        for (int i = 0; i < best_n; i++) begin
            v.px      = best_x[i][17:0];
            v.py      = best_y[i][17:0];
            v.last    = (i == best_n - 1);
            v.dropped = model_overflow;
            route_points = {route_points, v};
        end
        model_count    = 0;
        model_overflow = 1'b0;
    endtask

    function automatic req_beat_t box_beat(input int l, input int t, input int w, input int h);
        req_beat_t b;
        b.req  = 1'b0;
        b.data = {$urandom, $urandom, $urandom, $urandom};
        b.data[63:0] = {h[15:0], w[15:0], t[15:0], l[15:0]};
        return b;
    endfunction

    function automatic req_beat_t route_beat(input int sx, input int sy, input int tx, input int ty);
        req_beat_t b;
        b.req  = 1'b1;
        b.data = {$urandom, $urandom, $urandom, $urandom};
        b.data[127:64] = {ty[15:0], tx[15:0], sy[15:0], sx[15:0]};
        return b;
    endfunction

    function automatic int rnd16();
        logic [31:0] r;
        r = $urandom;
        return sx16(r[15:0]);
    endfunction

    // Driver: present queued beats, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_request({s_tuser, s_tdata});
            if (pending_beats.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                req_beat_t b;
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= b.req;
                s_tdata  <= b.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each vertex beat, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (route_points.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d", $signed(m_tdata[17:0]),
                           $signed(m_tdata[35:18]));
                    errors++;
                end else begin
                    vertex_t e;
                    e = route_points.pop_front();
                    if (m_tdata[17:0] !== e.px) begin
                        $error("point_x expected %0d got %0d", e.px, $signed(m_tdata[17:0]));
                        errors++;
                    end
                    if (m_tdata[35:18] !== e.py) begin
                        $error("point_y expected %0d got %0d", e.py, $signed(m_tdata[35:18]));
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_point expected %0b got %0b", e.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== e.dropped) begin
                        $error("dropped_boxes expected %0b got %0b", e.dropped, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000 && !done) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || route_points.size() != 0)
            @(posedge aclk);
        // a trailing load may still be in flight
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_clearance(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[9:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        model_pad = value;
    endtask

    // Random phase: batches of boxes around a field, then a route
    task automatic queue_random(input int routes);
        for (int r = 0; r < routes; r++) begin
            int nb;
            nb = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 4);
            for (int k = 0; k < nb; k++) begin
                if ($urandom_range(7) == 0)
                    add_beat(box_beat(rnd16(), rnd16(), rnd16(), rnd16()));
                else
                    add_beat(box_beat($urandom_range(0, 400) - 200,
                        $urandom_range(0, 400) - 200, $urandom_range(1, 120),
                        $urandom_range(1, 120)));
            end
            case ($urandom_range(3))
                0: add_beat(route_beat(rnd16(), rnd16(), rnd16(), rnd16()));
                1: begin
                    int x;
                    x = $urandom_range(0, 600) - 300;
                    add_beat(route_beat(x, $urandom_range(0, 600) - 300,
                        x, $urandom_range(0, 600) - 300));
                end
                default: add_beat(route_beat($urandom_range(0, 600) - 300,
                    $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                    $urandom_range(0, 600) - 300));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        model_pad = 0;
        hold_sender = 1'b0;
        done = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 87;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty and full boxes, extremes, same points, port sides
        add_beat(route_beat(5, 5, 5, 5));
        add_beat(route_beat(-32768, -32768, 32767, 32767));
        add_beat(box_beat(0, 0, 0, 10));
        add_beat(box_beat(0, 0, 10, -32768));
        add_beat(box_beat(0, 0, 100, 100));
        add_beat(route_beat(-50, 50, 150, 50));
        add_beat(box_beat(0, 0, 100, 100));
        add_beat(route_beat(100, 50, 0, 50));
        add_beat(box_beat(0, 0, 100, 100));
        add_beat(route_beat(50, 0, 50, 100));
        for (int k = 0; k < 17; k++)
            add_beat(box_beat(k * 30 - 255, -32768, 20, 32767));
        add_beat(route_beat(-300, 0, 300, 0));
        wait_drained();

        // Clearance at its top, overflow route with everything blocked
        set_clearance(1023);
        add_beat(box_beat(-32768, -32768, 32767, 32767));
        add_beat(route_beat(0, 0, 10, 10));
        queue_random(4);
        wait_drained();

        // Beats are queued while the sender is held back, then it is released
        set_clearance(7);
        hold_sender = 1'b1;
        queue_random(2);
        repeat (50) @(posedge aclk);
        hold_sender = 1'b0;
        wait_drained();
        queue_random(2);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 10;
        set_clearance(0);
        queue_random(3);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_clearance($urandom_range(1, 1022));
        queue_random(3);
        wait_drained();

        done = 1'b1;
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
